// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file to check its own logic.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define DRE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define DRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dre_pkg.sv =====
// Package for the dead reckoning extrapolator: constants, atan table,
// register indexes and controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package dre_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int POS_WIDTH    = 32;

    localparam int CSTEPS = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int CI_W   = $clog2(CSTEPS + 1);
    localparam int SUM_W  = ((POS_WIDTH > 34) ? POS_WIDTH : 34) + 1;

    localparam logic [14:0] TURN_UNITS = 15'd23040;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // heading to binary angle: h * 2^32 / 23040 = h * 2^23 / 45
    localparam logic [15:0] ANG_Q_RECIP = 16'd46604;      // ceil(2^21 / 45)
    localparam logic [29:0] ANG_F_RECIP = 30'd763549742;  // ceil(2^35 / 45)
    localparam logic [5:0]  ANG_DEN     = 6'd45;
    localparam logic [4:0]  ANG_HALF    = 5'd22;          // rounding term 11520 / 512

    // decay divider geometry
    localparam int DIV_REM_W = 22;
    localparam int DIV_LOW_W = 38;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_DECAY = 6'd38;

    typedef enum logic [3:0] {
        CFG_ORIGIN_X         = 4'd0,
        CFG_ORIGIN_Y         = 4'd1,
        CFG_SPEED            = 4'd2,
        CFG_HEADING          = 4'd3,
        CFG_DECAY_START_TIME = 4'd4,
        CFG_DECAY_END_TIME   = 4'd5,
        CFG_REPORT_TIME      = 4'd6,
        CFG_POSITION_VALID   = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic accept;
        logic flag_upd;
        logic mul_sds;
        logic mul_st;
        logic mul_stt;
        logic divc_start;
        logic ang_q;
        logic ang_r;
        logic ang_f;
        logic d2_load;
        logic cordic_init;
        logic cordic_step;
        logic quad;
        logic scl_lo;
        logic scl_hi;
        logic acc;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic special;
        logic case_c;
        logic div_done;
        logic cordic_done;
    } t_sts;

    // atan(2^-i) with 2^32 units per turn
    function automatic logic [29:0] atan_lookup(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dre_in_if.sv =====
// Input channel: one query time per transaction.
// No dependencies.
`default_nettype none

interface dre_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] query_time;

    modport source (output valid, output query_time, input ready);
    modport sink   (input valid, input query_time, output ready);
endinterface

`default_nettype wire

// ===== rtl/dre_out_if.sv =====
// Output channel: one extrapolated position per transaction.
// No dependencies.
`default_nettype none

interface dre_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               ok;
    logic               decay_maxed;

    modport source (output valid, output pos_x, output pos_y, output ok,
                    output decay_maxed, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input ok,
                    input decay_maxed, output ready);
endinterface

`default_nettype wire

// ===== rtl/dead_reckoning_decay_extrapolator_top.sv =====
// Sequence from accept to valid result: the special cases (no
// position, bad window, negative or zero elapsed time) go straight to the
// output; otherwise the CORDIC runs, and inside the decay window the 38-step divide runs first.
// One query in flight: input ready returns in the cycle after the result
// is loaded; a stalled result holds the block.
// Reset: i_rst_n synchronous active low; config and decay flag clear to 0.
`default_nettype none

`include "assert_macros.svh"

module dead_reckoning_decay_extrapolator_top
    import dre_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration writes, index is the register number
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    dre_in_if.sink           i_in,
    dre_out_if.source        o_out
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Controller: sequence of multiply, divide, CORDIC and scaling steps.
    dre_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Datapath: holds config, decay flag, arithmetic and the output payload.
    dre_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_query_time  (i_in.query_time),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_pos_x       (o_out.pos_x),
        .o_pos_y       (o_out.pos_y),
        .o_ok          (o_out.ok),
        .o_decay_maxed (o_out.decay_maxed)
    );

    // a result is only written when the output register is free or draining
    `DRE_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, w_cmd.load_out, !o_out.valid || o_out.ready, "result overwritten")
    // the decay divider is never restarted mid-run
    `DRE_ASSERT_IMPL(a_div_idle, i_clk, i_rst_n, w_cmd.divc_start, w_sts.div_done, "divider busy at start")
    // a transaction in hand blocks the next one
    `DRE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "accepted while busy")

endmodule

`default_nettype wire

// ===== rtl/dre_div.sv =====
// Restoring divider, one quotient bit per cycle, for the decay term
// S*t*t / R. Uses dre_pkg.
`default_nettype none

module dre_div
    import dre_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DIV_REM_W-1:0] i_rem,
    input  wire logic [DIV_LOW_W-1:0] i_low,
    input  wire logic [DIV_REM_W-1:0] i_den,
    input  wire logic [DIV_CNT_W-1:0] i_steps,
    output logic      [DIV_LOW_W-1:0] o_quo,
    output logic                      o_done
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_REM_W-1:0] r_rem;
    logic [DIV_LOW_W-1:0] r_low;
    logic [DIV_REM_W-1:0] r_den;
    logic [DIV_LOW_W-1:0] r_quo;

    logic [DIV_REM_W+1:0] w_trial;
    logic                 w_ge;

    assign w_trial = {1'b0, r_rem, r_low[DIV_LOW_W-1]} - {2'b00, r_den};
    assign w_ge    = ~w_trial[DIV_REM_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_low <= i_low;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_trial[DIV_REM_W-1:0] : {r_rem[DIV_REM_W-2:0], r_low[DIV_LOW_W-1]};
            r_low <= {r_low[DIV_LOW_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_LOW_W-2:0], w_ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = ~r_busy;

endmodule

`default_nettype wire

// ===== rtl/dre_datapath.sv =====
// Datapath: config registers, distance under the decay profile, CORDIC
// sine/cosine, displacement scaling and saturation. Uses dre_pkg, dre_div.
`default_nettype none

module dre_datapath
    import dre_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [3:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic [31:0]        i_query_time,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic                    o_ok,
    output logic                    o_decay_maxed
);

    // configuration
    logic signed [31:0] r_origin_x, r_origin_y;
    logic [15:0]        r_speed;
    logic [14:0]        r_heading;
    logic [21:0]        r_ds, r_de;
    logic [31:0]        r_report;
    logic               r_pos_valid;
    logic               r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_speed     <= '0;
            r_heading   <= '0;
            r_ds        <= '0;
            r_de        <= '0;
            r_report    <= '0;
            r_pos_valid <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X:         r_origin_x  <= i_cfg_data;
                CFG_ORIGIN_Y:         r_origin_y  <= i_cfg_data;
                CFG_SPEED:            r_speed     <= i_cfg_data[15:0];
                CFG_HEADING:          r_heading   <= i_cfg_data[14:0];
                CFG_DECAY_START_TIME: r_ds        <= i_cfg_data[21:0];
                CFG_DECAY_END_TIME:   r_de        <= i_cfg_data[21:0];
                CFG_REPORT_TIME:      r_report    <= i_cfg_data;
                CFG_POSITION_VALID:   r_pos_valid <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // classification of the query
    logic [31:0] r_query;
    logic [32:0] w_dt;
    logic [21:0] w_u22, w_t, w_rng, w_xop;
    logic        w_small, w_le_ds, w_le_de, w_case_a, w_case_b, w_case_c;
    logic        w_nopos, w_bad, w_zero, w_special;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_query <= i_query_time;
    end

    assign w_dt      = {1'b0, r_query} - {1'b0, r_report};
    assign w_u22     = w_dt[21:0];
    assign w_small   = (w_dt[32:22] == '0);
    assign w_le_ds   = w_small && (w_u22 <= r_ds);
    assign w_le_de   = w_small && (w_u22 <= r_de);
    assign w_case_a  = w_le_ds;
    assign w_case_b  = !w_le_ds && (r_de == r_ds);
    assign w_case_c  = !w_le_ds && !w_case_b && w_le_de;
    assign w_nopos   = !r_pos_valid;
    assign w_bad     = (r_de < r_ds) || w_dt[32];
    assign w_zero    = (w_dt == '0);
    assign w_special = w_nopos || w_bad || w_zero;
    assign w_t       = w_u22 - r_ds;
    assign w_rng     = r_de - r_ds;
    assign w_xop     = w_case_a ? w_u22 : (w_case_c ? w_t : w_rng);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)            r_flag <= 1'b0;
        else if (i_cmd.flag_upd) r_flag <= !w_case_a && !w_case_c;
    end

    // distance, D2 = 2 * distance
    logic [37:0] r_sds, r_st;
    logic [59:0] r_stt;
    logic [39:0] r_d2;
    logic [40:0] w_d2c;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_sds) r_sds <= 38'(r_speed) * 38'(r_ds);
        if (i_cmd.mul_st)  r_st  <= 38'(r_speed) * 38'(w_xop);
        if (i_cmd.mul_stt) r_stt <= 60'(r_st) * 60'(w_t);
    end

    // decay divider, S*t*t / R
    logic [DIV_LOW_W-1:0] w_quo;
    logic                 w_div_done;

    dre_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.divc_start),
        .i_rem   (r_stt[59:38]),
        .i_low   (r_stt[37:0]),
        .i_den   (w_rng),
        .i_steps (DIV_STEPS_DECAY),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    assign w_d2c = {2'b00, r_sds, 1'b0} + {2'b00, r_st, 1'b0} - {3'b000, w_quo};

    always_ff @(posedge i_clk) begin
        if (i_cmd.d2_load) begin
            if (w_case_a)      r_d2 <= {1'b0, r_st, 1'b0};
            else if (w_case_b) r_d2 <= {1'b0, r_sds, 1'b0};
            else if (w_case_c) r_d2 <= w_d2c[39:0];
            else               r_d2 <= {1'b0, r_sds, 1'b0} + {2'b00, r_st};
        end
    end

    // heading to binary angle: round(h * 2^32 / 23040) = floor((h*2^23 + 22) / 45)
    // = (h / 45) * 2^23 + floor((rem*2^23 + 22) / 45), both by reciprocal multiply
    logic [14:0] w_hmod;
    logic [29:0] w_qprod;
    logic [14:0] w_q45;
    logic [28:0] w_fnum;
    logic [57:0] w_fprod;
    logic [8:0]  r_aq;
    logic [14:0] r_ah;
    logic [5:0]  r_ar;
    logic [22:0] r_af;

    assign w_hmod  = (r_heading >= TURN_UNITS) ? (r_heading - TURN_UNITS) : r_heading;
    assign w_qprod = 30'(w_hmod) * 30'(ANG_Q_RECIP);
    assign w_q45   = 15'(r_aq) * 15'(ANG_DEN);
    assign w_fnum  = {r_ar, 23'd0} + 29'(ANG_HALF);
    assign w_fprod = 58'(w_fnum) * 58'(ANG_F_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ang_q) begin
            r_aq <= w_qprod[29:21];
            r_ah <= w_hmod;
        end
        if (i_cmd.ang_r) r_ar <= 6'(r_ah - w_q45);
        if (i_cmd.ang_f) r_af <= w_fprod[57:35];
    end

    // CORDIC, rotation mode, one iteration per cycle
    logic signed [33:0] r_cx, r_cy, w_shx, w_shy;
    logic signed [32:0] r_cz, w_at;
    logic [CI_W-1:0]    r_ci;
    logic [1:0]         r_quad;
    logic [4:0]         w_idx;
    logic               w_cdone;

    assign w_idx   = 5'(r_ci);
    assign w_shx   = r_cx >>> w_idx;
    assign w_shy   = r_cy >>> w_idx;
    assign w_at    = signed'({3'b000, atan_lookup(w_idx)});
    assign w_cdone = (r_ci == CI_W'(CSTEPS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_init) begin
            r_cx   <= CORDIC_GAIN;
            r_cy   <= '0;
            r_cz   <= signed'({3'b000, r_aq[6:0], r_af});
            r_quad <= r_aq[8:7];
            r_ci   <= '0;
        end else if (i_cmd.cordic_step) begin
            if (!r_cz[32]) begin
                r_cx <= r_cx - w_shy;
                r_cy <= r_cy + w_shx;
                r_cz <= r_cz - w_at;
            end else begin
                r_cx <= r_cx + w_shy;
                r_cy <= r_cy - w_shx;
                r_cz <= r_cz + w_at;
            end
            r_ci <= r_ci + 1'b1;
        end
    end

    // quadrant fold into sign and magnitude
    logic signed [33:0] w_sn, w_cs, w_sn_abs, w_cs_abs;
    logic               r_sn_neg, r_cs_neg;
    logic [32:0]        r_sn_mag, r_cs_mag;

    always_comb begin
        case (r_quad)
            2'd0:    begin w_sn = r_cy;  w_cs = r_cx;  end
            2'd1:    begin w_sn = r_cx;  w_cs = -r_cy; end
            2'd2:    begin w_sn = -r_cy; w_cs = -r_cx; end
            default: begin w_sn = -r_cx; w_cs = r_cy;  end
        endcase
    end

    assign w_sn_abs = w_sn[33] ? -w_sn : w_sn;
    assign w_cs_abs = w_cs[33] ? -w_cs : w_cs;

    always_ff @(posedge i_clk) begin
        if (i_cmd.quad) begin
            r_sn_neg <= w_sn[33];
            r_cs_neg <= w_cs[33];
            r_sn_mag <= w_sn_abs[32:0];
            r_cs_mag <= w_cs_abs[32:0];
        end
    end

    // displacement = round(D2 * |trig| / 2^41), in two 20-bit halves of D2
    logic [52:0] r_px_lo, r_px_hi, r_py_lo, r_py_hi;
    logic [73:0] w_accx, w_accy;
    logic [32:0] r_resx, r_resy;

    assign w_accx = {21'd0, r_px_lo} + {1'b0, r_px_hi, 20'd0} + (74'd1 << 40);
    assign w_accy = {21'd0, r_py_lo} + {1'b0, r_py_hi, 20'd0} + (74'd1 << 40);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scl_lo) begin
            r_px_lo <= 53'(r_d2[19:0]) * 53'(r_sn_mag);
            r_py_lo <= 53'(r_d2[19:0]) * 53'(r_cs_mag);
        end
        if (i_cmd.scl_hi) begin
            r_px_hi <= 53'(r_d2[39:20]) * 53'(r_sn_mag);
            r_py_hi <= 53'(r_d2[39:20]) * 53'(r_cs_mag);
        end
        if (i_cmd.acc) begin
            r_resx <= w_accx[73:41];
            r_resy <= w_accy[73:41];
        end
    end

    // origin + displacement, saturated
    localparam logic signed [SUM_W-1:0] POS_MAX =
        {{(SUM_W-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] POS_MIN = ~POS_MAX;

    logic signed [33:0]      w_dispx, w_dispy;
    logic signed [SUM_W-1:0] w_sumx, w_sumy, w_satx, w_saty;

    always_comb begin
        if (w_special) begin
            w_dispx = '0;
            w_dispy = '0;
        end else begin
            w_dispx = r_sn_neg ? -signed'({1'b0, r_resx}) : signed'({1'b0, r_resx});
            w_dispy = r_cs_neg ? -signed'({1'b0, r_resy}) : signed'({1'b0, r_resy});
        end
        w_sumx = SUM_W'(r_origin_x) + SUM_W'(w_dispx);
        w_sumy = SUM_W'(r_origin_y) + SUM_W'(w_dispy);
        w_satx = (w_sumx > POS_MAX) ? POS_MAX : ((w_sumx < POS_MIN) ? POS_MIN : w_sumx);
        w_saty = (w_sumy > POS_MAX) ? POS_MAX : ((w_sumy < POS_MIN) ? POS_MIN : w_sumy);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_pos_x       <= w_nopos ? 32'sd0 : w_satx[31:0];
            o_pos_y       <= w_nopos ? 32'sd0 : w_saty[31:0];
            o_ok          <= !w_nopos && !w_bad;
            o_decay_maxed <= r_flag;
        end
    end

    assign o_sts.special     = w_special;
    assign o_sts.case_c      = w_case_c;
    assign o_sts.div_done    = w_div_done;
    assign o_sts.cordic_done = w_cdone;

endmodule

`default_nettype wire

// ===== rtl/dre_ctrl.sv =====
// Controller FSM: sequences the datapath and owns both channel handshakes.
// Uses dre_pkg.
`default_nettype none

module dre_ctrl
    import dre_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_CLASS   = 15'b000000000000010,
        S_MSDS    = 15'b000000000000100,
        S_MST     = 15'b000000000001000,
        S_MSTT    = 15'b000000000010000,
        S_DVC_LD  = 15'b000000000100000,
        S_DVC_RUN = 15'b000000001000000,
        S_D2      = 15'b000000010000000,
        S_CINIT   = 15'b000000100000000,
        S_CRUN    = 15'b000001000000000,
        S_QUAD    = 15'b000010000000000,
        S_SCL_LO  = 15'b000100000000000,
        S_SCL_HI  = 15'b001000000000000,
        S_ACC     = 15'b010000000000000,
        S_SAT     = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) n_state = S_CLASS;
            end
            S_CLASS: begin
                if (i_sts.special) begin
                    n_state = S_SAT;
                end else begin
                    o_cmd.flag_upd = 1'b1;
                    n_state        = S_MSDS;
                end
            end
            S_MSDS: begin
                o_cmd.mul_sds = 1'b1;
                o_cmd.ang_q   = 1'b1;
                n_state       = S_MST;
            end
            S_MST: begin
                o_cmd.mul_st = 1'b1;
                o_cmd.ang_r  = 1'b1;
                n_state      = i_sts.case_c ? S_MSTT : S_D2;
            end
            S_MSTT: begin
                o_cmd.mul_stt = 1'b1;
                n_state       = S_DVC_LD;
            end
            S_DVC_LD: begin
                o_cmd.divc_start = 1'b1;
                n_state          = S_DVC_RUN;
            end
            S_DVC_RUN: begin
                if (i_sts.div_done) n_state = S_D2;
            end
            S_D2: begin
                o_cmd.d2_load = 1'b1;
                o_cmd.ang_f   = 1'b1;
                n_state       = S_CINIT;
            end
            S_CINIT: begin
                o_cmd.cordic_init = 1'b1;
                n_state           = S_CRUN;
            end
            S_CRUN: begin
                if (i_sts.cordic_done) n_state = S_QUAD;
                else                   o_cmd.cordic_step = 1'b1;
            end
            S_QUAD: begin
                o_cmd.quad = 1'b1;
                n_state    = S_SCL_LO;
            end
            S_SCL_LO: begin
                o_cmd.scl_lo = 1'b1;
                n_state      = S_SCL_HI;
            end
            S_SCL_HI: begin
                o_cmd.scl_hi = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_SAT;
            end
            S_SAT: begin
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out)   r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire
